// ===== sv/rta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pkg
// Shared constants, types and helpers for the radix to ASCII digit converter.
// ----------------------------------------------------------------------------
package rta_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int VALUE_BITS = 31;

  localparam int RADIX_W   = 4;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO        = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_LETTER_BASE = 7'd55;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE        = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_BAD
  } state_t;

  typedef struct packed {
    logic start;
    logic load;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_sts_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctl_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d <= DIGIT_NINE) begin
      return d_ext + ASCII_ZERO;
    end
    return d_ext + ASCII_LETTER_BASE;
  endfunction

endpackage

// ===== sv/rta_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_if
// Valid/ready request channels of the converter: number in, characters out.
// ----------------------------------------------------------------------------
interface rta_in_if import rta_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rta_out_if import rta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;
  logic              bad_radix;

  modport source (output valid, output digit_char, output last, output bad_radix,
                  input ready);
  modport sink   (input valid, input digit_char, input last, input bad_radix,
                  output ready);
endinterface

// ===== sv/radix_to_ascii_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_to_ascii_digits
// Converts a non-negative integer to ASCII digits in a base from 2 to 15.
// ----------------------------------------------------------------------------
// Takes one request at a time. Each digit costs one pass of a bit-serial
// divider, and the block stays busy until its last character is taken.
// The longest output is 31 digits, in base 2. Characters come out most
// significant first; the final one carries last. A radix of 0 or 1 returns
// one response with bad_radix and last set and digit_char zero.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits import rta_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rta_in_if.sink     in_ch,
  rta_out_if.source  out_ch
);

  state_t             state_r, state_nxt;
  div_ctl_t           div_ctl;
  div_sts_t           div_sts;
  stk_ctl_t           stk_ctl;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] top;
  logic [CNT_W-1:0]   count;
  logic               in_acc;
  logic               out_acc;
  logic               radix_ok;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign radix_ok = !(in_ch.radix inside {4'd0, 4'd1});

  rta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .value (in_ch.value),
    .radix (in_ch.radix),
    .sts   (div_sts),
    .rem   (rem)
  );

  rta_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .din   (rem),
    .top   (top),
    .count (count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = radix_ok ? ST_DIV : ST_BAD;
        end
      end
      ST_DIV: begin
        if (div_sts.done && div_sts.quo_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && count == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready       = 1'b0;
    div_ctl           = '0;
    stk_ctl           = '0;
    out_ch.valid      = 1'b0;
    out_ch.digit_char = '0;
    out_ch.last       = 1'b0;
    out_ch.bad_radix  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready   = 1'b1;
        stk_ctl.clear = in_acc;
        div_ctl.start = in_acc && radix_ok;
        div_ctl.load  = 1'b1;
      end
      ST_DIV: begin
        stk_ctl.push  = div_sts.done;
        div_ctl.start = div_sts.done && !div_sts.quo_zero;
      end
      ST_EMIT: begin
        out_ch.valid      = 1'b1;
        out_ch.digit_char = to_ascii(top);
        out_ch.last       = (count == CNT_W'(1));
        stk_ctl.pop       = out_acc;
      end
      ST_BAD: begin
        out_ch.valid     = 1'b1;
        out_ch.last      = 1'b1;
        out_ch.bad_radix = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/rta_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_div
// Bit-serial restoring divider: one quotient bit per cycle, the quotient
// stays in place so the next pass divides it again.
// ----------------------------------------------------------------------------
module rta_div import rta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_ctl_t              ctl,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  output div_sts_t              sts,
  output logic [DIGIT_W-1:0]    rem
);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    radix_r;
  logic [BIT_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic                  nz_r;
  logic [DIGIT_W:0]      trial;
  logic [DIGIT_W:0]      radix_ext;
  logic                  ge;

  assign trial     = {rem_r, quo_r[VALUE_BITS-1]};
  assign radix_ext = (DIGIT_W+1)'(radix_r);
  assign ge        = trial >= radix_ext;

  always_comb begin
    rem_nxt = ge ? DIGIT_W'(trial - radix_ext) : trial[DIGIT_W-1:0];
    quo_nxt = {quo_r[VALUE_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      nz_r   <= 1'b0;
      quo_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        nz_r   <= 1'b0;
        if (ctl.load) begin
          quo_r <= value;
        end
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        nz_r  <= nz_r | ge;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BIT_CNT_W'(VALUE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      if (ctl.load) begin
        radix_r <= radix;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign sts.done     = done_r;
  assign sts.quo_zero = !nz_r;
  assign rem          = rem_r;

endmodule

// ===== sv/rta_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_stack
// Digit stack as a shift line: digits enter least significant first and
// leave most significant first from the top tap.
// ----------------------------------------------------------------------------
module rta_stack import rta_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  stk_ctl_t           ctl,
  input  logic [DIGIT_W-1:0] din,
  output logic [DIGIT_W-1:0] top,
  output logic [CNT_W-1:0]   count
);

  logic [DIGIT_W-1:0] stk_r [MAX_DIGITS];
  logic [CNT_W-1:0]   count_r;
  logic               do_push;

  // once full, further (more significant) digits are dropped
  assign do_push = ctl.push && (count_r < CNT_W'(MAX_DIGITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
    end else if (do_push) begin
      count_r <= count_r + 1'b1;
    end else if (ctl.pop) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stk_r[0] <= din;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (ctl.pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  assign top   = stk_r[0];
  assign count = count_r;

endmodule

// ===== sv/rta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rta_checker import rta_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] digit_char,
  input logic              last,
  input logic              bad_radix
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digit_char))
    else $error("stalled response changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready for a request while responses pending");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_radix |-> last && digit_char == '0)
    else $error("bad radix response malformed");

endmodule

bind radix_to_ascii_digits rta_checker u_rta_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .digit_char (out_ch.digit_char),
  .last       (out_ch.last),
  .bad_radix  (out_ch.bad_radix)
);

// ===== tb/rta_digit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_digit_checker
// Watches both request channels of the converter, predicts the characters of
// every accepted number and compares each emitted character against them.
// ----------------------------------------------------------------------------
module rta_digit_checker import rta_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rta_in_if    in_ch,
  rta_out_if   out_ch,
  output int   fail_count,
  output int   chars_checked,
  output int   bad_requests,
  output int   open_chars
);

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              bad_radix;
  } char_exp_t;

  char_exp_t chars_due[$];

  function automatic void predict_chars(input logic [VALUE_BITS-1:0] val,
                                        input logic [RADIX_W-1:0] base);
    logic [DIGIT_W-1:0]    rems[MAX_DIGITS];
    logic [VALUE_BITS-1:0] quo;
    logic [CHAR_W-1:0]     ch;
    int                    n;
    char_exp_t             e;
    if (base < 2) begin
      e.digit_char = '0;
      e.last       = 1'b1;
      e.bad_radix  = 1'b1;
      chars_due.push_back(e);
      bad_requests++;
      return;
    end
    quo = val;
    n   = 0;
    do begin
      if (n < MAX_DIGITS) begin
        rems[n] = DIGIT_W'(quo % base);
        n++;
      end
      quo = quo / base;
    end while (quo != 0);
    for (int k = n - 1; k >= 0; k--) begin
      ch = CHAR_W'(rems[k]);
      e.digit_char = (rems[k] <= 9) ? ch + ASCII_ZERO : ch + ASCII_LETTER_BASE;
      e.last       = (k == 0);
      e.bad_radix  = 1'b0;
      chars_due.push_back(e);
    end
  endfunction

  initial begin
    fail_count    = 0;
    chars_checked = 0;
    bad_requests  = 0;
    open_chars    = 0;
  end

  always @(posedge clk) begin
    char_exp_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (chars_due.size() == 0) begin
          $error("unexpected character 0x%0h (last %0b bad_radix %0b)",
                 out_ch.digit_char, out_ch.last, out_ch.bad_radix);
          fail_count++;
        end else begin
          e = chars_due.pop_front();
          chars_checked++;
          if (out_ch.digit_char !== e.digit_char) begin
            $error("digit_char: expected 0x%0h, got 0x%0h", e.digit_char, out_ch.digit_char);
            fail_count++;
          end
          if (out_ch.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_ch.last);
            fail_count++;
          end
          if (out_ch.bad_radix !== e.bad_radix) begin
            $error("bad_radix: expected %0b, got %0b", e.bad_radix, out_ch.bad_radix);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_chars(in_ch.value, in_ch.radix);
      end
      open_chars <= chars_due.size();
    end
  end

endmodule

// ===== tb/tb_radix_to_ascii_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_to_ascii_digits
// Stimulus and verdict for the radix to ASCII digit converter.
// ----------------------------------------------------------------------------
// Sends a directed set of numbers (zero, the largest value, every base, bad
// bases, letter digits), then random requests with random idling on both
// sides, a stretch without idling and one long output hold-off. The checker
// beside the block predicts and compares every character.
// ----------------------------------------------------------------------------
module tb_radix_to_ascii_digits;
  import rta_pkg::*;

  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_REQS  = 500;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic tx_idle_en;
  logic rx_idle_en;
  logic hold_req;
  logic hold_done;
  int   reqs_sent;
  int   fail_count;
  int   chars_checked;
  int   bad_requests;
  int   open_chars;

  rta_in_if  in_ch();
  rta_out_if out_ch();

  radix_to_ascii_digits u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rta_digit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .chars_checked (chars_checked),
    .bad_requests  (bad_requests),
    .open_chars    (open_chars)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [VALUE_BITS-1:0] v, input logic [RADIX_W-1:0] r);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.radix <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reqs_sent++;
  endtask

  task automatic send_random;
    logic [VALUE_BITS-1:0] v;
    logic [RADIX_W-1:0]    r;
    int                    pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      v = VALUE_BITS'($urandom_range(255));
    end else if (pick < 50) begin
      v = VALUE_BITS'($urandom_range(65535));
    end else begin
      v = VALUE_BITS'($urandom);
    end
    if ($urandom_range(99) < 8) begin
      r = RADIX_W'($urandom_range(1));
    end else begin
      r = RADIX_W'($urandom_range(15, 2));
    end
    send_request(v, r);
  endtask

  initial begin
    rst_n       = 1'b0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    hold_req    = 1'b0;
    reqs_sent   = 0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.radix = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(31'd0, 4'd10);
    send_request(31'd0, 4'd2);
    send_request(31'd0, 4'd15);
    send_request(31'h7FFF_FFFF, 4'd2);
    send_request(31'h7FFF_FFFF, 4'd15);
    send_request(31'h7FFF_FFFF, 4'd10);
    send_request(31'h7FFF_FFFF, 4'd3);
    send_request(31'd5, 4'd0);
    send_request(31'h7FFF_FFFF, 4'd1);
    send_request(31'd0, 4'd0);
    send_request(31'd1, 4'd2);
    send_request(31'd9, 4'd10);
    send_request(31'd10, 4'd11);
    send_request(31'd11, 4'd12);
    send_request(31'd12, 4'd13);
    send_request(31'd13, 4'd14);
    send_request(31'd14, 4'd15);
    send_request(31'd224, 4'd15);
    send_request(31'h4000_0000, 4'd2);
    send_request(31'h2AAA_AAAA, 4'd4);
    send_request(31'd100, 4'd5);
    send_request(31'd65535, 4'd6);
    send_request(31'd123456789, 4'd7);
    send_request(31'd255, 4'd8);
    send_request(31'd80, 4'd9);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 150) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (i == 250) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      if (i == 300) begin
        hold_req = 1'b1;
      end
      send_random();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_chars != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d numbers, %0d of them with a base below two.", reqs_sent, bad_requests);
    $display("Checked %0d characters across bases 0 to 15.", chars_checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
